// ===== hdl/glpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid local peak detector package
// Shared constants, register codes, result and queue status types and the peak comparison.
// ----------------------------------------------------------------------------
package glpd_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int DATA_W   = 32;
  localparam int DIM_W    = 11;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CFG_W    = 2;

  localparam logic [DIM_W-1:0]  ROWS_RESET   = DIM_W'(2);
  localparam logic [DIM_W-1:0]  COLS_RESET   = DIM_W'(2);
  localparam logic [DATA_W-1:0] BORDER_RESET = '1;

  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 8;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_W-1:0] {
    REG_GRID_ROWS,
    REG_GRID_COLS,
    REG_BORDER_VALUE
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     is_peak;
    logic                     frame_end;
  } result_t;

  typedef struct packed {
    logic [QCNT_W-1:0] fill;
    logic              room;
  } queue_status_t;

  function automatic logic peak_test(
    input logic signed [DATA_W-1:0] ctr,
    input logic signed [DATA_W-1:0] top,
    input logic signed [DATA_W-1:0] left,
    input logic signed [DATA_W-1:0] right,
    input logic signed [DATA_W-1:0] below
  );
    return (ctr > top) && (ctr > left) && (ctr > right) && (ctr > below);
  endfunction

endpackage

// ===== hdl/glpd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data, read-first.
// ----------------------------------------------------------------------------
module glpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

// ===== hdl/glpd_slot.sv =====
// ----------------------------------------------------------------------------
// Result queue cell
// Holds one result; loads a new one or takes its neighbor's on a pop.
// ----------------------------------------------------------------------------
module glpd_slot (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              load,
  input  glpd_pkg::result_t load_data,
  input  logic              next_valid,
  input  glpd_pkg::result_t next_data,
  output logic              valid,
  output glpd_pkg::result_t data
);
  import glpd_pkg::*;

  logic    valid_next;
  result_t data_next;

  always_comb begin
    valid_next = valid;
    data_next  = data;
    if (load) begin
      valid_next = 1'b1;
      data_next  = load_data;
    end else if (shift) begin
      valid_next = next_valid;
      data_next  = next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    data <= data_next;
  end

endmodule

// ===== hdl/glpd_result_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Chain of result cells draining toward the output; packs up to four
// results of one sample into the free cells behind the queued ones.
// ----------------------------------------------------------------------------
module glpd_result_queue (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [glpd_pkg::MAX_RES-1:0]             cand_valid,
  input  glpd_pkg::result_t [glpd_pkg::MAX_RES-1:0] cand,
  input  logic                                     pop,
  output logic                                     head_valid,
  output glpd_pkg::result_t                        head,
  output glpd_pkg::queue_status_t                  status
);
  import glpd_pkg::*;

  localparam int SUM_W = QCNT_W + 1;

  logic [QCNT_W-1:0] fill;
  logic [QCNT_W-1:0] fill_next;
  logic [QCNT_W-1:0] base;
  logic [QCNT_W-1:0] push_cnt;
  logic [QCNT_W-1:0] pos [MAX_RES];
  logic [QDEPTH-1:0] slot_valid;
  result_t           slot_data [QDEPTH];

  always_comb begin
    pos[0] = '0;
    for (int k = 1; k < MAX_RES; k++) begin
      pos[k] = pos[k-1] + QCNT_W'(cand_valid[k-1]);
    end
    push_cnt  = pos[MAX_RES-1] + QCNT_W'(cand_valid[MAX_RES-1]);
    base      = fill - QCNT_W'(pop);
    fill_next = base + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  for (genvar i = 0; i < QDEPTH; i++) begin : g_slot
    logic    load;
    result_t load_data;
    logic    nb_valid;
    result_t nb_data;

    always_comb begin
      load      = 1'b0;
      load_data = '0;
      for (int k = 0; k < MAX_RES; k++) begin
        if (cand_valid[k] && ({1'b0, base} + {1'b0, pos[k]}) == SUM_W'(i)) begin
          load      = 1'b1;
          load_data = cand[k];
        end
      end
    end

    if (i == QDEPTH - 1) begin : g_tail
      assign nb_valid = 1'b0;
      assign nb_data  = '0;
    end else begin : g_link
      assign nb_valid = slot_valid[i+1];
      assign nb_data  = slot_data[i+1];
    end

    glpd_slot u_slot (
      .clk        (clk),
      .rst        (rst),
      .shift      (pop),
      .load       (load),
      .load_data  (load_data),
      .next_valid (nb_valid),
      .next_data  (nb_data),
      .valid      (slot_valid[i]),
      .data       (slot_data[i])
    );
  end

  assign head_valid  = slot_valid[0];
  assign head        = slot_data[0];
  assign status.fill = fill;
  assign status.room = ({1'b0, fill} + {1'b0, push_cnt} + SUM_W'(MAX_RES))
                       <= SUM_W'(QDEPTH);

endmodule

// ===== hdl/grid_local_peak_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Grid local peak detector
// Finds samples strictly above their four orthogonal neighbors in a
// row-major grid stream and reports them with their coordinates.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_write                  cfg_index, cfg_data
// sample    in         sample_valid/sample_ready  sample_value
// peak      out        peak_valid/peak_ready      peak_value, peak_row, peak_col,
//                                                 is_peak, frame_end
//
// One sample per cycle while sample_ready is high; results leave one per cycle
// while peak_ready is high, from an eight-cell queue. Stage one judges cells in
// the cycle after acceptance, from the registered reads of the two line RAMs.
// Reset needs no clearing pass; line RAM contents start undefined.
// sample_ready drops only while the queue lacks room for four more results.
// ----------------------------------------------------------------------------
module grid_local_peak_detector_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [glpd_pkg::CFG_W-1:0]           cfg_index,
  input  logic [glpd_pkg::DATA_W-1:0]          cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic signed [glpd_pkg::DATA_W-1:0]   sample_value,
  output logic                                 peak_valid,
  input  logic                                 peak_ready,
  output logic signed [glpd_pkg::DATA_W-1:0]   peak_value,
  output logic [glpd_pkg::ROW_W-1:0]           peak_row,
  output logic [glpd_pkg::COL_W-1:0]           peak_col,
  output logic                                 is_peak,
  output logic                                 frame_end
);
  import glpd_pkg::*;

  logic [DIM_W-1:0]         grid_rows;
  logic [DIM_W-1:0]         grid_cols;
  logic signed [DATA_W-1:0] border_value;

  logic [ROW_W-1:0]         row_cnt;
  logic [COL_W-1:0]         col_cnt;
  logic                     byp;
  logic signed [DATA_W-1:0] byp_value;

  logic                     s1_valid;
  logic [ROW_W-1:0]         s1_row;
  logic [COL_W-1:0]         s1_col;
  logic                     s1_last_row;
  logic                     s1_last_col;

  logic signed [DATA_W-1:0] up0;
  logic signed [DATA_W-1:0] up1;
  logic signed [DATA_W-1:0] cur0;
  logic signed [DATA_W-1:0] cur1;
  logic signed [DATA_W-1:0] cur2;

  logic [DIM_W-1:0]         rows_eff;
  logic [DIM_W-1:0]         cols_eff;
  logic                     last_row;
  logic                     last_col;
  logic                     accept;
  logic                     pop;
  logic [COL_W-1:0]         next_col;
  logic [DATA_W-1:0]        above_rdata;
  logic [DATA_W-1:0]        two_rdata;
  logic signed [DATA_W-1:0] above_cur;
  logic signed [DATA_W-1:0] b;

  logic                     s1_r0;
  logic                     s1_r1;
  logic                     s1_c0;
  logic                     s1_c1;
  logic [MAX_RES-1:0]       cand_valid;
  result_t [MAX_RES-1:0]    cand;
  result_t                  head;
  queue_status_t            q_status;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= ROWS_RESET;
      grid_cols    <= COLS_RESET;
      border_value <= BORDER_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_ROWS:    grid_rows    <= cfg_data[DIM_W-1:0];
        REG_GRID_COLS:    grid_cols    <= cfg_data[DIM_W-1:0];
        REG_BORDER_VALUE: border_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = DIM_W'(1);
    end else if (grid_rows > DIM_W'(MAX_ROWS)) begin
      rows_eff = DIM_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
    if (grid_cols == '0) begin
      cols_eff = DIM_W'(1);
    end else if (grid_cols > DIM_W'(MAX_COLS)) begin
      cols_eff = DIM_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols;
    end
  end

  assign b         = border_value;
  assign last_row  = DIM_W'(row_cnt) >= (rows_eff - DIM_W'(1));
  assign last_col  = DIM_W'(col_cnt) >= (cols_eff - DIM_W'(1));
  assign next_col  = last_col ? '0 : col_cnt + COL_W'(1);
  assign accept    = sample_valid && sample_ready;
  assign above_cur = byp ? byp_value : $signed(above_rdata);

  // line stores: previous row and the row before it
  glpd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col_cnt),
    .wdata (sample_value),
    .re    (accept),
    .raddr (next_col),
    .rdata (above_rdata)
  );

  glpd_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_two_above (
    .clk   (clk),
    .we    (accept),
    .waddr (col_cnt),
    .wdata (above_cur),
    .re    (accept),
    .raddr (col_cnt),
    .rdata (two_rdata)
  );

  // raster position, write-through bypass and stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt  <= '0;
      col_cnt  <= '0;
      byp      <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        byp <= (next_col == col_cnt);
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= last_row ? '0 : row_cnt + ROW_W'(1);
        end else begin
          col_cnt <= next_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_value   <= sample_value;
      s1_row      <= row_cnt;
      s1_col      <= col_cnt;
      s1_last_row <= last_row;
      s1_last_col <= last_col;
      up0         <= above_cur;
      up1         <= up0;
      cur0        <= sample_value;
      cur1        <= cur0;
      cur2        <= cur1;
    end
  end

  // stage one: judge up to three cells and add the frame-end marker
  assign s1_r0 = (s1_row == '0);
  assign s1_r1 = (s1_row == ROW_W'(1));
  assign s1_c0 = (s1_col == '0);
  assign s1_c1 = (s1_col == COL_W'(1));

  always_comb begin
    cand_valid[0] = s1_valid && !s1_r0 &&
                    peak_test(up0,
                              s1_r1 ? b : $signed(two_rdata),
                              s1_c0 ? b : up1,
                              s1_last_col ? b : $signed(above_rdata),
                              cur0);
    cand_valid[1] = s1_valid && s1_last_row && !s1_c0 &&
                    peak_test(cur1, s1_r0 ? b : up1, s1_c1 ? b : cur2, cur0, b);
    cand_valid[2] = s1_valid && s1_last_row && s1_last_col &&
                    peak_test(cur0, s1_r0 ? b : up0, s1_c0 ? b : cur1, b, b);
    cand_valid[3] = s1_valid && s1_last_row && s1_last_col;

    cand[0].value     = up0;
    cand[0].row       = s1_row - ROW_W'(1);
    cand[0].col       = s1_col;
    cand[0].is_peak   = 1'b1;
    cand[0].frame_end = 1'b0;

    cand[1].value     = cur1;
    cand[1].row       = s1_row;
    cand[1].col       = s1_col - COL_W'(1);
    cand[1].is_peak   = 1'b1;
    cand[1].frame_end = 1'b0;

    cand[2].value     = cur0;
    cand[2].row       = s1_row;
    cand[2].col       = s1_col;
    cand[2].is_peak   = 1'b1;
    cand[2].frame_end = 1'b0;

    cand[3].value     = '0;
    cand[3].row       = '0;
    cand[3].col       = '0;
    cand[3].is_peak   = 1'b0;
    cand[3].frame_end = 1'b1;
  end

  assign pop = peak_valid && peak_ready;

  glpd_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand       (cand),
    .pop        (pop),
    .head_valid (peak_valid),
    .head       (head),
    .status     (q_status)
  );

  assign sample_ready = q_status.room;
  assign peak_value   = head.value;
  assign peak_row     = head.row;
  assign peak_col     = head.col;
  assign is_peak      = head.is_peak;
  assign frame_end    = head.frame_end;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.fill <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_head_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    peak_valid == (q_status.fill != '0))
    else $error("queue head valid disagrees with fill count");

  a_marker_clean: assert property (@(posedge clk) disable iff (rst)
    (peak_valid && frame_end) |-> (!is_peak && peak_value == '0))
    else $error("frame-end marker carries a peak");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid local peak detector testbench
// Streams sample grids through grid_local_peak_detector_unit under random
// source gaps and sink stalls, predicts every peak report and frame marker
// from its own copy of the line stores and counters, and checks each
// transaction on the result channel in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import glpd_pkg::*;

  typedef logic signed [DATA_W-1:0] sample_t;

  localparam sample_t S_MAX = 32'sh7FFF_FFFF;
  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam logic [CFG_W-1:0] REG_SPARE = CFG_W'(3);
  localparam int RANDOM_ITEMS = 315;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 60;

  class peak_tracker;
    logic [DIM_W-1:0] rows_cfg;
    logic [DIM_W-1:0] cols_cfg;
    sample_t          border;
    sample_t          line_above [MAX_COLS];
    sample_t          line_two_above [MAX_COLS];
    sample_t          prev_sample;
    int unsigned      row_ctr;
    int unsigned      col_ctr;
    result_t          pending_peaks [$];
    int unsigned      fault_count;

    function new();
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      border = BORDER_RESET;
      foreach (line_above[i]) begin
        line_above[i] = '0;
        line_two_above[i] = '0;
      end
      prev_sample = '0;
      row_ctr = 0;
      col_ctr = 0;
      fault_count = 0;
    endfunction

    function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function void load_register(logic [CFG_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_GRID_ROWS:    rows_cfg = data[DIM_W-1:0];
        REG_GRID_COLS:    cols_cfg = data[DIM_W-1:0];
        REG_BORDER_VALUE: border = data;
        default: ;
      endcase
    endfunction

    function void consider_cell(sample_t ctr, sample_t up, sample_t lf, sample_t rt,
                                sample_t dn, int unsigned row, int unsigned col);
      result_t rep;
      if (ctr > up && ctr > lf && ctr > rt && ctr > dn) begin
        rep.value = ctr;
        rep.row = ROW_W'(row);
        rep.col = COL_W'(col);
        rep.is_peak = 1'b1;
        rep.frame_end = 1'b0;
        pending_peaks.insert(pending_peaks.size(), rep);
      end
    endfunction

    // Note an accepted sample and queue the reports it decides.
    function void take_sample(sample_t x);
      int unsigned nrows, ncols, r, c;
      bit end_col, end_row;
      sample_t up, lf, rt;
      result_t marker;
      nrows = eff_dim(rows_cfg, MAX_ROWS);
      ncols = eff_dim(cols_cfg, MAX_COLS);
      r = row_ctr;
      c = col_ctr;
      end_col = (c >= ncols - 1);
      end_row = (r >= nrows - 1);
      if (r >= 1) begin
        up = (r == 1) ? border : line_two_above[c];
        lf = (c == 0) ? border : line_two_above[c-1];
        rt = end_col ? border : line_above[c+1];
        consider_cell(line_above[c], up, lf, rt, x, r - 1, c);
      end
      line_two_above[c] = line_above[c];
      line_above[c] = x;
      if (end_row) begin
        if (c >= 1) begin
          lf = (c == 1) ? border : line_above[c-2];
          up = (r == 0) ? border : line_two_above[c-1];
          consider_cell(prev_sample, up, lf, x, border, r, c - 1);
        end
        if (end_col) begin
          lf = (c == 0) ? border : prev_sample;
          up = (r == 0) ? border : line_two_above[c];
          consider_cell(x, up, lf, border, border, r, c);
          marker = '0;
          marker.frame_end = 1'b1;
          pending_peaks.insert(pending_peaks.size(), marker);
        end
      end
      prev_sample = x;
      if (end_col) begin
        col_ctr = 0;
        row_ctr = end_row ? 0 : r + 1;
      end else begin
        col_ctr = c + 1;
      end
    endfunction

    function void log_fault(string what, result_t want, result_t got);
      fault_count++;
      if (fault_count <= 10)
        $display("%s at %0t: want v=%0d r=%0d c=%0d p=%b e=%b, got v=%0d r=%0d c=%0d p=%b e=%b",
                 what, $time, want.value, want.row, want.col, want.is_peak, want.frame_end,
                 got.value, got.row, got.col, got.is_peak, got.frame_end);
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (pending_peaks.size() == 0) begin
        log_fault("unexpected result", '0, got);
        return;
      end
      want = pending_peaks.pop_front();
      if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
          got.is_peak !== want.is_peak || got.frame_end !== want.frame_end)
        log_fault("mismatch", want, got);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  logic [CFG_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic             sample_valid;
  logic             sample_ready;
  sample_t          sample_value;
  logic             peak_valid;
  logic             peak_ready;
  sample_t          peak_value;
  logic [ROW_W-1:0] peak_row;
  logic [COL_W-1:0] peak_col;
  logic             is_peak;
  logic             frame_end;

  peak_tracker tracker = new();
  bit gaps_on;
  bit stalls_on;
  bit hold_req;
  int samples_sent;

  grid_local_peak_detector_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .peak_valid   (peak_valid),
    .peak_ready   (peak_ready),
    .peak_value   (peak_value),
    .peak_row     (peak_row),
    .peak_col     (peak_col),
    .is_peak      (is_peak),
    .frame_end    (frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && peak_valid && peak_ready)
      tracker.check_report(result_t'({peak_value, peak_row, peak_col, is_peak, frame_end}));
  end

  // Result sink: random stalls plus one long hold on request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    peak_ready = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        peak_ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        peak_ready = 1'b0;
      end else if (stalls_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        peak_ready = 1'b0;
      end else begin
        peak_ready = 1'b1;
      end
    end
  end

  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic sample_t pick_value();
    case ($urandom_range(0, 9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return sample_t'($urandom);
      default: return sample_t'($urandom_range(0, 6)) - sample_t'(3);
    endcase
  endfunction

  task automatic push(input sample_t v);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      sample_valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
    @(negedge clk);
    sample_valid = 1'b1;
    sample_value = v;
    do @(posedge clk); while (!sample_ready);
    tracker.take_sample(v);
    samples_sent++;
  endtask

  task automatic send_frame();
    do push(pick_value()); while (tracker.row_ctr != 0 || tracker.col_ctr != 0);
  endtask

  // Drop valid, wait out every expected result, then let the pipeline empty.
  task automatic drain();
    @(negedge clk);
    sample_valid = 1'b0;
    while (tracker.pending_peaks.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.load_register(idx, data);
  endtask

  task automatic random_phase();
    int unsigned nr, nc;
    nr = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
    nc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
    write_reg(REG_GRID_ROWS, nr);
    write_reg(REG_GRID_COLS, nc);
    write_reg(REG_BORDER_VALUE, pick_value());
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) push(pick_value());
        if (tracker.row_ctr != 0 || tracker.col_ctr != 0) begin
          // shrink mid-frame so the current row or frame ends early
          drain();
          if ($urandom_range(0, 1) == 0)
            write_reg(REG_GRID_COLS, $urandom_range(1, tracker.col_ctr + 1));
          else
            write_reg(REG_GRID_ROWS, $urandom_range(1, tracker.row_ctr + 1));
        end
      end
      send_frame();
    end
    drain();
  endtask

  initial begin
    int goal;
    bit quiet;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_valid = 1'b0;
    sample_value = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    samples_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset grid 2x2, border -1
    push(5); push(1); push(1); push(-3);
    push(S_MIN); push(S_MAX); push(S_MAX); push(S_MIN);
    drain();

    // zero dimensions act as a single cell
    write_reg(REG_GRID_ROWS, 0);
    write_reg(REG_GRID_COLS, 0);
    write_reg(REG_BORDER_VALUE, S_MIN);
    push(S_MIN); push(S_MIN + 1); push(S_MAX);
    drain();

    write_reg(REG_GRID_ROWS, 1);
    write_reg(REG_GRID_COLS, 3);
    write_reg(REG_BORDER_VALUE, S_MAX);
    push(S_MAX); push(0); push(S_MAX);
    drain();
    write_reg(REG_SPARE, 5);

    // dimensions cut mid-frame
    write_reg(REG_GRID_ROWS, 3);
    write_reg(REG_GRID_COLS, 4);
    write_reg(REG_BORDER_VALUE, 0);
    push(1); push(4); push(1); push(2); push(0); push(1);
    drain();
    write_reg(REG_GRID_COLS, 2);
    push(3); push(1);
    drain();
    write_reg(REG_GRID_ROWS, 2);
    push(2);
    drain();

    // oversized dimensions clamp to the maximum
    write_reg(REG_GRID_ROWS, 1);
    write_reg(REG_GRID_COLS, 2047);
    write_reg(REG_BORDER_VALUE, BORDER_RESET);
    repeat (5) push(pick_value());
    drain();
    write_reg(REG_GRID_COLS, 6);
    send_frame();
    drain();
    write_reg(REG_GRID_ROWS, 2047);
    write_reg(REG_GRID_COLS, 2);
    repeat (4) push(pick_value());
    drain();
    write_reg(REG_GRID_ROWS, 3);
    send_frame();
    drain();

    // hold the sink while single-cell frames keep coming
    write_reg(REG_GRID_ROWS, 1);
    write_reg(REG_GRID_COLS, 1);
    write_reg(REG_BORDER_VALUE, S_MIN);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (30) push(pick_value());
    drain();

    goal = samples_sent + RANDOM_ITEMS;
    while (samples_sent < goal) begin
      quiet = (samples_sent + QUIET_ITEMS >= goal);
      gaps_on = !quiet && ($urandom_range(0, 3) != 0);
      stalls_on = !quiet && ($urandom_range(0, 3) != 0);
      random_phase();
    end

    drain();
    if (tracker.fault_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
